[rtl/lpbs_pkg.sv]
// Shared types and constants for the LED pixel buffer serializer.
// Used by lpbs_scaler and led_pixel_buffer_serializer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lpbs_pkg;

    localparam int COLOR_W   = 8;
    localparam int PIXEL_W   = 3 * COLOR_W;
    localparam int INDEX_W   = 16;
    localparam int TICK_W    = 10;
    localparam int COUNT_W   = 9;
    localparam int BITPOS_W  = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [BITPOS_W-1:0] LAST_BIT = BITPOS_W'(PIXEL_W - 1);

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_SHOW  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BUSY  = 2'd2
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW    = 3'd4;

    localparam logic [COUNT_W-1:0] RST_PIXEL_COUNT = 9'd1;
    localparam logic [TICK_W-1:0]  RST_ONE_HIGH    = 10'd40;
    localparam logic [TICK_W-1:0]  RST_ONE_LOW     = 10'd23;
    localparam logic [TICK_W-1:0]  RST_ZERO_HIGH   = 10'd20;
    localparam logic [TICK_W-1:0]  RST_ZERO_LOW    = 10'd43;

endpackage

`default_nettype wire

[rtl/lpbs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lpbs_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/lpbs_scaler.sv]
// Brightness scaler: each channel becomes (c * brightness) / 255, packed as GRB.
// Depends on lpbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpbs_scaler (
    input  wire logic [lpbs_pkg::COLOR_W-1:0] i_red,
    input  wire logic [lpbs_pkg::COLOR_W-1:0] i_green,
    input  wire logic [lpbs_pkg::COLOR_W-1:0] i_blue,
    input  wire logic [lpbs_pkg::COLOR_W-1:0] i_brightness,
    output logic      [lpbs_pkg::PIXEL_W-1:0] o_grb
);

    // x / 255 for x <= 255*255 is (x + (x >> 8) + 1) >> 8
    function automatic logic [lpbs_pkg::COLOR_W-1:0] scale(
        input logic [lpbs_pkg::COLOR_W-1:0] c,
        input logic [lpbs_pkg::COLOR_W-1:0] br
    );
        logic [2*lpbs_pkg::COLOR_W-1:0] prod;
        logic [2*lpbs_pkg::COLOR_W:0]   sum;
        prod  = c * br;
        sum   = {1'b0, prod} + (2*lpbs_pkg::COLOR_W+1)'(prod >> lpbs_pkg::COLOR_W) + 1'b1;
        scale = sum[2*lpbs_pkg::COLOR_W-1:lpbs_pkg::COLOR_W];
    endfunction

    assign o_grb = {scale(i_green, i_brightness),
                    scale(i_red, i_brightness),
                    scale(i_blue, i_brightness)};

endmodule

`default_nettype wire

[rtl/led_pixel_buffer_serializer.sv]
// LED strip driver: pixel store plus one-wire GRB serializer with per-bit timing.
// Depends on lpbs_pkg, lpbs_ram and lpbs_scaler.
//
// Usage: each slave transfer carries a request in s_axis_tuser (write pixel, show,
// tick, clear and show) and the write operands in s_axis_tdata. Every request
// gives exactly one result transfer with the data line level, the busy flag and
// a status code; m_axis_tlast marks the tick that ends the last bit of a frame.
// One tick request advances the line waveform by one step of its phase counters,
// so the host sends ticks at its line clock and reads the level from each result.
// A result is offered once its request has passed the input register and then
// the result register. Throughput: one request per cycle while results are taken,
// set by the update of the serializer state between those two registers.
// The next pixel word is fetched from the store RAM while the current one is
// shifted out; a pixel lasts at least 48 ticks, far longer than the fetch.
// Reset: registers take their default timing values, the serializer goes idle
// and all store entries read as zero at once (per-entry valid flags, no sweep).
// Clear does the same to the store and starts a frame of zeros.
// Stall: when m_axis_tready is low the result is held, the input register
// fills, and s_axis_tready drops until the result is taken.
// Configuration writes take effect at the edge where i_cfg_we is high.
`timescale 1ns / 1ps
`default_nettype none

module led_pixel_buffer_serializer #(
    parameter int MAX_PIXELS = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [lpbs_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [lpbs_pkg::TICK_W-1:0]       i_cfg_wdata,
    // request stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [15:0] pixel_index, [23:16] red_value, [31:24] green_value,
    // [39:32] blue_value, [47:40] brightness
    input  wire logic [47:0]                       s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]                        s_axis_tuser,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] line_level, [1] busy_res, [3:2] status, [7:4] zero
    output logic [7:0]                             m_axis_tdata,
    // frame_done
    output logic                                   m_axis_tlast
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int PW = $clog2(MAX_PIXELS + 1);
    localparam int CW = (PW > lpbs_pkg::COUNT_W) ? PW : lpbs_pkg::COUNT_W;
    localparam int PXW = lpbs_pkg::PIXEL_W;

    // configuration registers
    logic [lpbs_pkg::COUNT_W-1:0] r_cfg_pixel_count;
    logic [lpbs_pkg::TICK_W-1:0]  r_cfg_one_high;
    logic [lpbs_pkg::TICK_W-1:0]  r_cfg_one_low;
    logic [lpbs_pkg::TICK_W-1:0]  r_cfg_zero_high;
    logic [lpbs_pkg::TICK_W-1:0]  r_cfg_zero_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pixel_count <= lpbs_pkg::RST_PIXEL_COUNT;
            r_cfg_one_high    <= lpbs_pkg::RST_ONE_HIGH;
            r_cfg_one_low     <= lpbs_pkg::RST_ONE_LOW;
            r_cfg_zero_high   <= lpbs_pkg::RST_ZERO_HIGH;
            r_cfg_zero_low    <= lpbs_pkg::RST_ZERO_LOW;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lpbs_pkg::CFG_PIXEL_COUNT:
                    r_cfg_pixel_count <= i_cfg_wdata[lpbs_pkg::COUNT_W-1:0];
                lpbs_pkg::CFG_ONE_HIGH:  r_cfg_one_high  <= i_cfg_wdata;
                lpbs_pkg::CFG_ONE_LOW:   r_cfg_one_low   <= i_cfg_wdata;
                lpbs_pkg::CFG_ZERO_HIGH: r_cfg_zero_high <= i_cfg_wdata;
                lpbs_pkg::CFG_ZERO_LOW:  r_cfg_zero_low  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective pixel count, clamped to 1..MAX_PIXELS
    logic [CW-1:0] w_active;
    always_comb begin
        w_active = CW'(r_cfg_pixel_count);
        if (w_active == '0) begin
            w_active = CW'(1);
        end
        if (w_active > CW'(MAX_PIXELS)) begin
            w_active = CW'(MAX_PIXELS);
        end
    end

    // input register
    logic                         r_s1_valid;
    lpbs_pkg::t_req               r_req;
    logic [lpbs_pkg::INDEX_W-1:0] r_idx;
    logic [lpbs_pkg::COLOR_W-1:0] r_red;
    logic [lpbs_pkg::COLOR_W-1:0] r_green;
    logic [lpbs_pkg::COLOR_W-1:0] r_blue;
    logic [lpbs_pkg::COLOR_W-1:0] r_bright;

    // result register
    logic                 r_out_valid;
    logic                 r_out_line;
    logic                 r_out_busy;
    lpbs_pkg::t_status    r_out_status;
    logic                 r_out_done;

    logic w_s1_go;
    assign w_s1_go       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req    <= lpbs_pkg::t_req'(s_axis_tuser);
            r_idx    <= s_axis_tdata[15:0];
            r_red    <= s_axis_tdata[23:16];
            r_green  <= s_axis_tdata[31:24];
            r_blue   <= s_axis_tdata[39:32];
            r_bright <= s_axis_tdata[47:40];
        end
    end

    // serializer state
    logic                          r_sending;
    logic                          r_low_phase;
    logic [PW-1:0]                 r_pix_pos;
    logic [lpbs_pkg::BITPOS_W-1:0] r_bit_pos;
    logic [lpbs_pkg::TICK_W-1:0]   r_tick_cnt;
    logic [PXW-1:0]                r_shift;
    logic [PXW-1:0]                r_pix0;
    logic [MAX_PIXELS-1:0]         r_valid;
    logic                          r_rd_valid;

    logic                          n_sending;
    logic                          n_low_phase;
    logic [PW-1:0]                 n_pix_pos;
    logic [lpbs_pkg::BITPOS_W-1:0] n_bit_pos;
    logic [lpbs_pkg::TICK_W-1:0]   n_tick_cnt;
    logic [PXW-1:0]                n_shift;
    logic [PXW-1:0]                n_pix0;
    logic [MAX_PIXELS-1:0]         n_valid;
    lpbs_pkg::t_status             n_status;
    logic                          n_done;
    logic                          w_ram_we;

    // store: pixel 0 lives in r_pix0 so a frame can start at once
    logic [PXW-1:0] w_scaled;
    logic [AW-1:0]  w_waddr;
    logic [AW-1:0]  w_raddr;
    logic [PXW-1:0] w_ram_q;
    logic [PXW-1:0] w_next_word;

    lpbs_scaler u_scaler (
        .i_red        (r_red),
        .i_green      (r_green),
        .i_blue       (r_blue),
        .i_brightness (r_bright),
        .o_grb        (w_scaled)
    );

    assign w_waddr = r_idx[AW-1:0];
    assign w_raddr = AW'(r_pix_pos + PW'(1));

    lpbs_ram #(
        .WIDTH (PXW),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_s1_go && w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_scaled),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[w_raddr];
    end

    assign w_next_word = r_rd_valid ? w_ram_q : '0;

    // phase timing
    logic                        w_bit_one;
    logic [lpbs_pkg::TICK_W-1:0] w_len;
    logic [lpbs_pkg::TICK_W-1:0] w_cnt_inc;
    logic                        w_idx_ok;

    always_comb begin
        w_bit_one = r_shift[PXW-1];
        if (r_low_phase) begin
            w_len = w_bit_one ? r_cfg_one_low : r_cfg_zero_low;
        end else begin
            w_len = w_bit_one ? r_cfg_one_high : r_cfg_zero_high;
        end
        if (w_len == '0) begin
            w_len = lpbs_pkg::TICK_W'(1);
        end
        w_cnt_inc = r_tick_cnt + lpbs_pkg::TICK_W'(1);
        w_idx_ok  = r_idx < lpbs_pkg::INDEX_W'(w_active);
    end

    always_comb begin
        n_sending   = r_sending;
        n_low_phase = r_low_phase;
        n_pix_pos   = r_pix_pos;
        n_bit_pos   = r_bit_pos;
        n_tick_cnt  = r_tick_cnt;
        n_shift     = r_shift;
        n_pix0      = r_pix0;
        n_valid     = r_valid;
        n_status    = lpbs_pkg::ST_OK;
        n_done      = 1'b0;
        w_ram_we    = 1'b0;
        case (r_req)
            lpbs_pkg::REQ_TICK: begin
                if (r_sending) begin
                    if (w_cnt_inc < w_len) begin
                        n_tick_cnt = w_cnt_inc;
                    end else begin
                        n_tick_cnt = '0;
                        if (!r_low_phase) begin
                            n_low_phase = 1'b1;
                        end else begin
                            n_low_phase = 1'b0;
                            n_shift     = {r_shift[PXW-2:0], 1'b0};
                            if (r_bit_pos != lpbs_pkg::LAST_BIT) begin
                                n_bit_pos = r_bit_pos + lpbs_pkg::BITPOS_W'(1);
                            end else begin
                                // pixel finished: end the frame or load the next word
                                n_bit_pos = '0;
                                if (CW'(r_pix_pos) + CW'(1) >= w_active) begin
                                    n_sending = 1'b0;
                                    n_pix_pos = '0;
                                    n_shift   = '0;
                                    n_done    = 1'b1;
                                end else begin
                                    n_pix_pos = r_pix_pos + PW'(1);
                                    n_shift   = w_next_word;
                                end
                            end
                        end
                    end
                end
            end
            lpbs_pkg::REQ_WRITE: begin
                if (r_sending) begin
                    n_status = lpbs_pkg::ST_BUSY;
                end else if (!w_idx_ok) begin
                    n_status = lpbs_pkg::ST_RANGE;
                end else begin
                    w_ram_we         = 1'b1;
                    n_valid[w_waddr] = 1'b1;
                    if (r_idx == '0) begin
                        n_pix0 = w_scaled;
                    end
                end
            end
            lpbs_pkg::REQ_SHOW: begin
                if (r_sending) begin
                    n_status = lpbs_pkg::ST_BUSY;
                end else begin
                    n_sending   = 1'b1;
                    n_low_phase = 1'b0;
                    n_pix_pos   = '0;
                    n_bit_pos   = '0;
                    n_tick_cnt  = '0;
                    n_shift     = r_pix0;
                end
            end
            lpbs_pkg::REQ_CLEAR: begin
                if (r_sending) begin
                    n_status = lpbs_pkg::ST_BUSY;
                end else begin
                    // drop every entry at once, then send a frame of zeros
                    n_valid     = '0;
                    n_pix0      = '0;
                    n_sending   = 1'b1;
                    n_low_phase = 1'b0;
                    n_pix_pos   = '0;
                    n_bit_pos   = '0;
                    n_tick_cnt  = '0;
                    n_shift     = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending   <= 1'b0;
            r_low_phase <= 1'b0;
            r_pix_pos   <= '0;
            r_bit_pos   <= '0;
            r_tick_cnt  <= '0;
            r_shift     <= '0;
            r_pix0      <= '0;
            r_valid     <= '0;
        end else if (w_s1_go) begin
            r_sending   <= n_sending;
            r_low_phase <= n_low_phase;
            r_pix_pos   <= n_pix_pos;
            r_bit_pos   <= n_bit_pos;
            r_tick_cnt  <= n_tick_cnt;
            r_shift     <= n_shift;
            r_pix0      <= n_pix0;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            r_out_line   <= n_sending && !n_low_phase;
            r_out_busy   <= n_sending;
            r_out_status <= n_status;
            r_out_done   <= n_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_status, r_out_busy, r_out_line};
    assign m_axis_tlast  = r_out_done;

    // checks
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> !r_out_busy && !r_out_line)
        else $error("frame end reported while still busy");

    a_low_needs_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_phase |-> r_sending)
        else $error("low phase outside a frame");

    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> r_pix_pos == '0 && r_bit_pos == '0 && r_tick_cnt == '0)
        else $error("serializer counters not parked while idle");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_pos <= lpbs_pkg::LAST_BIT)
        else $error("bit position out of range");

endmodule

`default_nettype wire

[tb/tb_led_pixel_buffer_serializer.sv]
// Self-checking bench for led_pixel_buffer_serializer: pixel writes, show and clear
// frames, tick-driven line waveform, status codes and register settings.
// Depends on lpbs_pkg and the led_pixel_buffer_serializer RTL; nothing else.
`timescale 1ns / 1ps

module tb_led_pixel_buffer_serializer;

    import lpbs_pkg::*;

    localparam int STRIP_MAX = 256;

    typedef struct packed {
        logic    line;
        logic    busy;
        t_status status;
        logic    done;
    } report_t;

    // One row of the directed plan: either a register write or a request.
    typedef struct packed {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] reg_addr;
        logic [TICK_W-1:0]    reg_data;
        t_req                 req;
        logic [47:0]          word;
        logic [15:0]          reps;
        logic                 flush;
        logic                 typed;
        report_t              want;
    } step_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr    = '0;
    logic [TICK_W-1:0]    i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;

    // Strip model state and register copies
    logic [PIXEL_W-1:0]  frame_store [STRIP_MAX];
    logic                on_air      = 1'b0;
    logic [COUNT_W-1:0]  pix_pos     = '0;
    logic [BITPOS_W-1:0] bit_pos     = '0;
    logic                in_low      = 1'b0;
    logic [TICK_W-1:0]   phase_ticks = '0;
    logic [PIXEL_W-1:0]  out_word    = '0;
    logic [COUNT_W-1:0]  cnt_reg     = RST_PIXEL_COUNT;
    logic [TICK_W-1:0]   one_hi      = RST_ONE_HIGH;
    logic [TICK_W-1:0]   one_lo      = RST_ONE_LOW;
    logic [TICK_W-1:0]   zero_hi     = RST_ZERO_HIGH;
    logic [TICK_W-1:0]   zero_lo     = RST_ZERO_LOW;

    report_t reports_due [$];
    step_t   plan [$];
    bit      gaps_on         = 1'b1;
    int      mismatches      = 0;
    int      results_checked = 0;
    int      items_sent      = 0;
    int      frames_seen     = 0;
    int      reg_writes      = 0;

    led_pixel_buffer_serializer #(.MAX_PIXELS(STRIP_MAX)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    function automatic int pixels_in_use();
        if (cnt_reg == '0) return 1;
        if (cnt_reg > STRIP_MAX) return STRIP_MAX;
        return int'(cnt_reg);
    endfunction

    function automatic logic [7:0] dim(logic [7:0] c, logic [7:0] br);
        logic [15:0] prod;
        prod = c * br;
        return 8'(prod / 16'd255);
    endfunction

    // Advance the waveform by one tick; return 1 when the last low phase ends.
    function automatic bit strip_tick();
        logic [TICK_W-1:0] span;
        if (in_low) span = out_word[PIXEL_W-1] ? one_lo : zero_lo;
        else        span = out_word[PIXEL_W-1] ? one_hi : zero_hi;
        if (span == '0) span = 10'd1;
        phase_ticks = phase_ticks + 10'd1;
        if (phase_ticks < span) return 1'b0;
        phase_ticks = '0;
        if (!in_low) begin
            in_low = 1'b1;
            return 1'b0;
        end
        in_low   = 1'b0;
        out_word = out_word << 1;
        bit_pos  = bit_pos + 5'd1;
        if (bit_pos < PIXEL_W) return 1'b0;
        bit_pos = '0;
        pix_pos = pix_pos + 9'd1;
        if (pix_pos >= pixels_in_use()) begin
            on_air   = 1'b0;
            pix_pos  = '0;
            out_word = '0;
            return 1'b1;
        end
        out_word = frame_store[pix_pos[7:0]];
        return 1'b0;
    endfunction

    function automatic report_t step_strip(t_req req, logic [47:0] word);
        report_t     rep;
        logic [15:0] idx;
        logic [7:0]  br;
        rep = '{line: 1'b0, busy: 1'b0, status: ST_OK, done: 1'b0};
        idx = word[15:0];
        br  = word[47:40];
        if (req == REQ_TICK) begin
            if (on_air) rep.done = strip_tick();
        end else if (on_air) begin
            rep.status = ST_BUSY;
        end else if (req == REQ_WRITE) begin
            if (idx >= pixels_in_use()) begin
                rep.status = ST_RANGE;
            end else begin
                frame_store[idx[7:0]] = {dim(word[31:24], br), dim(word[23:16], br),
                                         dim(word[39:32], br)};
            end
        end else begin
            if (req == REQ_CLEAR) foreach (frame_store[k]) frame_store[k] = '0;
            on_air      = 1'b1;
            pix_pos     = '0;
            bit_pos     = '0;
            in_low      = 1'b0;
            phase_ticks = '0;
            out_word    = frame_store[0];
        end
        rep.line = on_air && !in_low;
        rep.busy = on_air;
        return rep;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [47:0] filler();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [47:0] pack_px(logic [15:0] idx, logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b, logic [7:0] br);
        return {br, b, g, r, idx};
    endfunction

    // Mostly in-range indexes, with the boundary and the full 16-bit range mixed in.
    function automatic logic [47:0] random_pixel();
        int          roll;
        logic [15:0] idx;
        logic [7:0]  br;
        roll = $urandom_range(0, 99);
        if (roll < 85)      idx = 16'($urandom_range(0, pixels_in_use() - 1));
        else if (roll < 90) idx = 16'(pixels_in_use());
        else                idx = 16'($urandom_range(0, 65535));
        roll = $urandom_range(0, 7);
        br = (roll == 0) ? 8'hFF : ((roll == 1) ? 8'h00 : 8'($urandom_range(0, 255)));
        return {br, 24'($urandom()), idx};
    endfunction

    function automatic logic [TICK_W-1:0] pick_span(bit big);
        if (big) return TICK_W'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) return TICK_W'($urandom_range(6, 12));
        return TICK_W'($urandom_range(0, 5));
    endfunction

    function automatic step_t ask(t_req req, logic [47:0] word, int reps, bit flush);
        step_t s;
        s       = '0;
        s.req   = req;
        s.word  = word;
        s.reps  = 16'(reps);
        s.flush = flush;
        return s;
    endfunction

    function automatic step_t ask_typed(t_req req, logic [47:0] word, logic line, logic busy,
                                        t_status st, bit flush);
        step_t s;
        s       = ask(req, word, 1, flush);
        s.typed = 1'b1;
        s.want  = '{line: line, busy: busy, status: st, done: 1'b0};
        return s;
    endfunction

    function automatic step_t set_reg(logic [CFG_IDX_W-1:0] addr, logic [TICK_W-1:0] data);
        step_t s;
        s          = '0;
        s.is_reg   = 1'b1;
        s.reg_addr = addr;
        s.reg_data = data;
        return s;
    endfunction

    task automatic send_item(t_req req, logic [47:0] word, bit typed, report_t given);
        int      gap;
        report_t rep;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        rep = step_strip(req, word);
        reports_due.push_back(typed ? given : rep);
        items_sent++;
        if (rep.done) frames_seen++;
    endtask

    task automatic run_out_frame();
        while (on_air) send_item(REQ_TICK, filler(), 1'b0, '0);
    endtask

    // Drop valid and hold until every result is back, plus the pipeline depth.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [TICK_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            CFG_PIXEL_COUNT: cnt_reg = data[COUNT_W-1:0];
            CFG_ONE_HIGH:    one_hi  = data;
            CFG_ONE_LOW:     one_lo  = data;
            CFG_ZERO_HIGH:   zero_hi = data;
            CFG_ZERO_LOW:    zero_lo = data;
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Result side: handshake values are stable between rising edges, so sample
    // at the falling edge for the transfer that completes at the next rising one.
    always @(negedge i_clk) begin
        report_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reports_due.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h tlast %b",
                       m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                if (m_axis_tdata[0] !== want.line) begin
                    $error("line_level: expected %0d, got %0d", want.line, m_axis_tdata[0]);
                    mismatches++;
                end
                if (m_axis_tdata[1] !== want.busy) begin
                    $error("busy_res: expected %0d, got %0d", want.busy, m_axis_tdata[1]);
                    mismatches++;
                end
                if (m_axis_tdata[3:2] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[3:2]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.done) begin
                    $error("frame_done: expected %0d, got %0d", want.done, m_axis_tlast);
                    mismatches++;
                end
                results_checked++;
            end
        end
    end

    // Receiver: ready bursts of random length, mostly short stalls, some long runs.
    initial begin
        int run;
        int stall;
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        #240_000_000;
        $display("timeout with %0d results still due", reports_due.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int                ops;
        int                roll;
        int                frame_budget;
        bit                big;
        logic [TICK_W-1:0] count_val;

        foreach (frame_store[k]) frame_store[k] = '0;

        // Reset settings, idle tick, range checks, refusals while sending
        plan.push_back(ask_typed(REQ_TICK, '0, 1'b0, 1'b0, ST_OK, 1'b0));
        plan.push_back(ask_typed(REQ_WRITE, pack_px(16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                                 1'b0, 1'b0, ST_OK, 1'b0));
        plan.push_back(ask_typed(REQ_WRITE, pack_px(16'h0001, 8'h11, 8'h22, 8'h33, 8'hFF),
                                 1'b0, 1'b0, ST_RANGE, 1'b0));
        plan.push_back(ask_typed(REQ_WRITE, pack_px(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                                 1'b0, 1'b0, ST_RANGE, 1'b0));
        plan.push_back(ask(REQ_WRITE, pack_px(16'h0000, 8'h80, 8'h01, 8'hFF, 8'h7F), 1, 1'b0));
        plan.push_back(ask_typed(REQ_SHOW, '0, 1'b1, 1'b1, ST_OK, 1'b0));
        plan.push_back(ask_typed(REQ_WRITE, pack_px(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00),
                                 1'b1, 1'b1, ST_BUSY, 1'b0));
        plan.push_back(ask_typed(REQ_SHOW, '0, 1'b1, 1'b1, ST_BUSY, 1'b0));
        plan.push_back(ask_typed(REQ_CLEAR, '0, 1'b1, 1'b1, ST_BUSY, 1'b0));
        plan.push_back(ask(REQ_TICK, '0, 1, 1'b1));
        // Zero pixel count and zero phase lengths act as one
        plan.push_back(set_reg(CFG_PIXEL_COUNT, 10'd0));
        plan.push_back(set_reg(CFG_ONE_HIGH, 10'd0));
        plan.push_back(set_reg(CFG_ONE_LOW, 10'd0));
        plan.push_back(set_reg(CFG_ZERO_HIGH, 10'd0));
        plan.push_back(set_reg(CFG_ZERO_LOW, 10'd0));
        plan.push_back(ask_typed(REQ_WRITE, pack_px(16'h0001, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                                 1'b0, 1'b0, ST_RANGE, 1'b0));
        plan.push_back(ask(REQ_WRITE, pack_px(16'h0000, 8'hFF, 8'h00, 8'hAA, 8'h80), 1, 1'b0));
        plan.push_back(ask_typed(REQ_CLEAR, '0, 1'b1, 1'b1, ST_OK, 1'b1));
        // Pixel count above the store size acts as the store size
        plan.push_back(set_reg(CFG_PIXEL_COUNT, 10'd511));
        plan.push_back(ask_typed(REQ_WRITE, pack_px(16'd255, 8'h00, 8'hFF, 8'h00, 8'hFF),
                                 1'b0, 1'b0, ST_OK, 1'b0));
        plan.push_back(ask_typed(REQ_WRITE, pack_px(16'd256, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                                 1'b0, 1'b0, ST_RANGE, 1'b0));
        plan.push_back(ask(REQ_SHOW, '0, 1, 1'b1));
        // Shrink the pixel count while the second pixel is on the line
        plan.push_back(set_reg(CFG_PIXEL_COUNT, 10'd4));
        plan.push_back(ask(REQ_WRITE, pack_px(16'd3, 8'h12, 8'h34, 8'h56, 8'hFF), 1, 1'b0));
        plan.push_back(ask(REQ_SHOW, '0, 1, 1'b0));
        plan.push_back(ask(REQ_TICK, '0, 60, 1'b0));
        plan.push_back(set_reg(CFG_PIXEL_COUNT, 10'd2));
        plan.push_back(ask(REQ_TICK, '0, 1, 1'b1));
        // Longest phases, for a one bit and then for a zero bit
        plan.push_back(set_reg(CFG_PIXEL_COUNT, 10'd1));
        plan.push_back(set_reg(CFG_ONE_HIGH, 10'd1023));
        plan.push_back(set_reg(CFG_ONE_LOW, 10'd1023));
        plan.push_back(set_reg(CFG_ZERO_HIGH, 10'd1));
        plan.push_back(set_reg(CFG_ZERO_LOW, 10'd1));
        plan.push_back(ask(REQ_WRITE, pack_px(16'h0000, 8'h00, 8'h00, 8'h01, 8'hFF), 1, 1'b0));
        plan.push_back(ask(REQ_SHOW, '0, 1, 1'b1));
        plan.push_back(set_reg(CFG_ONE_HIGH, 10'd1));
        plan.push_back(set_reg(CFG_ONE_LOW, 10'd1));
        plan.push_back(set_reg(CFG_ZERO_HIGH, 10'd1023));
        plan.push_back(set_reg(CFG_ZERO_LOW, 10'd1023));
        plan.push_back(ask(REQ_WRITE, pack_px(16'h0000, 8'hFF, 8'hFF, 8'hFE, 8'hFF), 1, 1'b0));
        plan.push_back(ask(REQ_SHOW, '0, 1, 1'b1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].is_reg) begin
                drain_results();
                write_reg(plan[n].reg_addr, plan[n].reg_data);
            end else begin
                repeat (plan[n].reps) send_item(plan[n].req, plan[n].word, plan[n].typed,
                                                plan[n].want);
                if (plan[n].flush) run_out_frame();
            end
        end

        // Random phases: fresh settings, pixel writes, frames run to the end
        for (int phase = 0; phase < 12; phase++) begin
            drain_results();
            big = ($urandom_range(0, 4) == 0);
            count_val = big ? 10'($urandom_range(9, 511)) : 10'($urandom_range(0, 8));
            if ($urandom_range(0, 7) == 0) count_val[9] = 1'b1;
            write_reg(CFG_PIXEL_COUNT, count_val);
            write_reg(CFG_ONE_HIGH, pick_span(big));
            write_reg(CFG_ONE_LOW, pick_span(big));
            write_reg(CFG_ZERO_HIGH, pick_span(big));
            write_reg(CFG_ZERO_LOW, pick_span(big));
            gaps_on = ($urandom_range(0, 3) != 0);
            // keep long strips to a single frame per phase
            frame_budget = big ? 1 : 1000;
            ops = 0;
            while (ops < 40) begin
                roll = $urandom_range(0, 99);
                if (on_air) begin
                    if (roll < 5) begin
                        send_item((roll < 2) ? REQ_WRITE : ((roll < 4) ? REQ_SHOW : REQ_CLEAR),
                                  random_pixel(), 1'b0, '0);
                        ops++;
                    end else begin
                        send_item(REQ_TICK, filler(), 1'b0, '0);
                    end
                end else begin
                    if (roll < 70) begin
                        send_item(REQ_WRITE, random_pixel(), 1'b0, '0);
                    end else if (roll < 80 && frame_budget > 0) begin
                        send_item(REQ_SHOW, filler(), 1'b0, '0);
                        frame_budget--;
                    end else if (roll < 85 && frame_budget > 0) begin
                        send_item(REQ_CLEAR, filler(), 1'b0, '0);
                        frame_budget--;
                    end else begin
                        send_item(REQ_TICK, filler(), 1'b0, '0);
                    end
                    ops++;
                end
            end
            if (on_air && $urandom_range(0, 3) == 0) begin
                drain_results();
                write_reg(CFG_PIXEL_COUNT, 10'($urandom_range(1, 8)));
            end
            run_out_frame();
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("sent %0d requests over %0d register writes, %0d frames completed",
                 items_sent, reg_writes, frames_seen);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
